FILE: hdl/pod_pkg.sv
`default_nettype none
package pod_pkg;

	localparam int MAX_CELLS = 32;
	localparam int DEF_PALETTE_DEPTH = 32;
	localparam logic [5:0] PALETTE_SIZE_RESET = 6'd32;

	// Squared channel weights of the nearest-entry search.
	localparam logic [11:0] W2_GREEN = 12'd3481;
	localparam logic [11:0] W2_RED = 12'd900;
	localparam logic [11:0] W2_BLUE = 12'd121;
	localparam logic [11:0] W2_ALPHA = 12'd64;

	// Weights of the threshold distance.
	localparam logic [12:0] K_RED = 13'd2126;
	localparam logic [12:0] K_GREEN = 13'd7152;
	localparam logic [12:0] K_BLUE = 13'd722;
	localparam logic [14:0] K_ALPHA = 15'd20000;

	localparam logic [5:0] BAYER [64] = '{
		6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
		6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
		6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
		6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
		6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
		6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
		6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
		6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
	};

	// One item as it travels through both search chains.
	typedef struct packed {
		logic        op;
		logic [4:0]  widx;
		logic [23:0] wcol;
		logic [7:0]  pr;
		logic [7:0]  pg;
		logic [7:0]  pb;
		logic [7:0]  pa;
		logic [2:0]  xp;
		logic [2:0]  yp;
		logic [7:0]  sr;
		logic [7:0]  sg;
		logic [7:0]  sb;
		logic [22:0] sat;
		logic [4:0]  best;
		logic [22:0] low;
		logic [23:0] bcol;
		logic [23:0] c0;
		logic [4:0]  best1;
		logic [23:0] col1;
	} item_t;

	function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [22:0] wsq(input logic [4:0] a, input logic [4:0] b,
			input logic [11:0] w2);
		logic [4:0] d;
		logic [9:0] sq;
		d = (a > b) ? a - b : b - a;
		sq = 10'(d * d);
		return 23'(sq * w2);
	endfunction

	// Alpha term of the search; every searched entry is opaque.
	function automatic logic [22:0] alpha_term(input logic [7:0] a);
		return wsq(5'd31, a[7:3], W2_ALPHA);
	endfunction

	function automatic logic [7:0] reflect(input logic [7:0] p, input logic [7:0] e);
		logic signed [10:0] v;
		logic [10:0] m;
		v = $signed({2'b00, p, 1'b0}) - $signed({3'b000, e});
		m = (v < 0) ? 11'(-v) : 11'(v);
		return (m > 11'd255) ? 8'd255 : m[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: hdl/pod_cell.sv
`default_nettype none
module pod_cell #(
	parameter int IDX = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic [5:0]    lim,
	input  wire logic          vin,
	input  wire pod_pkg::item_t din,
	output logic               vout,
	output pod_pkg::item_t     dout
);

	logic [23:0] pal_q;
	pod_pkg::item_t nxt;
	logic [22:0] s;

	// Palette writes travel with the stream, so each pixel sees the palette
	// exactly as it stood when the pixel entered.
	always_ff @(posedge clk) begin
		if (adv && vin && !din.op && din.widx == 5'(IDX)) begin
			pal_q <= din.wcol;
		end
	end

	assign s = pod_pkg::wsq(pal_q[15:11], din.sg[7:3], pod_pkg::W2_GREEN)
		+ pod_pkg::wsq(pal_q[23:19], din.sr[7:3], pod_pkg::W2_RED)
		+ pod_pkg::wsq(pal_q[7:3], din.sb[7:3], pod_pkg::W2_BLUE)
		+ din.sat;

	generate
		if (IDX == 0) begin : g_head
			always_comb begin
				nxt = din;
				nxt.c0 = pal_q;
				nxt.bcol = pal_q;
				nxt.best = '0;
				nxt.low = '1;
			end
		end else begin : g_search
			always_comb begin
				nxt = din;
				if (din.op && din.pa != 8'd0 && 6'(IDX) < lim && s < din.low) begin
					nxt.best = 5'(IDX);
					nxt.low = s;
					nxt.bcol = pal_q;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (adv) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dout <= nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/palette_ordered_dither.sv
`default_nettype none
// Ordered dither of RGBA pixels to a palette of up to 32 RGB entries with an 8x8
// Bayer matrix. A transfer with tuser 0 writes a palette entry and gives no result;
// a transfer with tuser 1 dithers one pixel and gives exactly one result carrying
// the chosen index, its color and the pixel alpha. Entry 0 is the transparent
// entry and is chosen for every pixel with alpha 0. The block is a pipeline that
// takes one transfer every cycle unless the output stalls; a pixel passes 2*N+5
// register stages, where N = min(PALETTE_DEPTH, 32) is the number of cells in the
// first chain, one register stage per entry; the second has none for entry 0.
// Palette writes flow down the same pipeline, so a pixel always uses the palette as
// it was when the pixel was accepted. palette_size may only be written while the
// pipeline is empty. A stall at the output holds the whole pipeline.
module palette_ordered_dither #(
	parameter int PALETTE_DEPTH = pod_pkg::DEF_PALETTE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        palette_size_we,
	input  wire logic [5:0]  palette_size_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// entry_index, entry_red, entry_green, entry_blue, pixel_red, pixel_green,
	// pixel_blue, pixel_alpha, x_phase, y_phase; bits 71:67 are zero
	input  wire logic [71:0] s_tdata,
	input  wire logic        s_tuser, // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// palette_index, out_red, out_green, out_blue, out_alpha; bits 39:37 are zero
	output logic [39:0]      m_tdata
);

	localparam int N = (PALETTE_DEPTH < pod_pkg::MAX_CELLS) ? PALETTE_DEPTH
		: pod_pkg::MAX_CELLS;

	// Decision stages after the second search.
	typedef struct packed {
		logic        op;
		logic [7:0]  pa;
		logic [4:0]  i1;
		logic [4:0]  i2;
		logic [23:0] col1;
		logic [23:0] col2;
		logic [23:0] c0;
		logic [7:0]  dr;
		logic [7:0]  dg;
		logic [7:0]  db;
		logic [7:0]  da;
		logic [7:0]  er;
		logic [7:0]  eg;
		logic [7:0]  eb;
		logic [7:0]  ea;
		logic [6:0]  th1;
		logic [22:0] d;
		logic [22:0] dd;
		logic [28:0] d64;
		logic [28:0] m;
	} dec_t;

	logic [5:0] palette_size_q;
	logic adv;

	logic v_s0, v_rf, v_da, v_db, v_dc, v_dd;
	pod_pkg::item_t item_s0, item_rf;
	pod_pkg::item_t c1_d [N+1];
	logic           c1_v [N+1];
	pod_pkg::item_t c2_d [N];
	logic           c2_v [N];
	dec_t dec_da, dec_db, dec_dc;
	dec_t nxt_da, nxt_db, nxt_dc;
	pod_pkg::item_t nxt_s0, nxt_rf, tail1, tail2;
	logic [7:0] a1_rf, ra_rf;
	logic op_dd;
	logic [4:0] idx_dd;
	logic [23:0] col_dd;
	logic [7:0] alpha_dd;
	logic [4:0] idx_nx;
	logic [23:0] col_nx;

	// The whole pipeline moves together unless a finished result is refused.
	assign adv = !(m_tvalid && !m_tready);
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= pod_pkg::PALETTE_SIZE_RESET;
		end else if (palette_size_we) begin
			palette_size_q <= palette_size_wdata;
		end
	end

	// Input register: unpack the transfer and precompute the pixel alpha term.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (adv) begin
			v_s0 <= s_tvalid;
		end
	end

	always_comb begin
		nxt_s0 = '0;
		nxt_s0.op = s_tuser;
		nxt_s0.widx = s_tdata[4:0];
		nxt_s0.wcol = {s_tdata[12:5], s_tdata[20:13], s_tdata[28:21]};
		nxt_s0.pr = s_tdata[36:29];
		nxt_s0.pg = s_tdata[44:37];
		nxt_s0.pb = s_tdata[52:45];
		nxt_s0.pa = s_tdata[60:53];
		nxt_s0.xp = s_tdata[63:61];
		nxt_s0.yp = s_tdata[66:64];
		nxt_s0.sr = s_tdata[36:29];
		nxt_s0.sg = s_tdata[44:37];
		nxt_s0.sb = s_tdata[52:45];
		nxt_s0.sat = pod_pkg::alpha_term(s_tdata[60:53]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0 <= nxt_s0;
		end
	end

	// First chain: cell 0 picks up the transparent entry's color, cells 1..N-1
	// search for the nearest entry to the pixel.
	assign c1_d[0] = item_s0;
	assign c1_v[0] = v_s0;

	generate
		for (genvar k = 0; k < N; k++) begin : g_chain1
			pod_cell #(.IDX(k)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.adv   (adv),
				.lim   (palette_size_q),
				.vin   (c1_v[k]),
				.din   (c1_d[k]),
				.vout  (c1_v[k+1]),
				.dout  (c1_d[k+1])
			);
		end
	endgenerate

	// Reflect the pixel through the nearest color; the result is what the
	// second chain searches for.
	assign tail1 = c1_d[N];
	assign a1_rf = (tail1.best != 5'd0) ? 8'd255 : 8'd0;
	assign ra_rf = pod_pkg::reflect(tail1.pa, a1_rf);

	always_comb begin
		nxt_rf = tail1;
		nxt_rf.best1 = tail1.best;
		nxt_rf.col1 = tail1.bcol;
		nxt_rf.sr = pod_pkg::reflect(tail1.pr, tail1.bcol[23:16]);
		nxt_rf.sg = pod_pkg::reflect(tail1.pg, tail1.bcol[15:8]);
		nxt_rf.sb = pod_pkg::reflect(tail1.pb, tail1.bcol[7:0]);
		nxt_rf.sat = pod_pkg::alpha_term(ra_rf);
		nxt_rf.best = '0;
		nxt_rf.low = '1;
		nxt_rf.bcol = tail1.c0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rf <= 1'b0;
		end else if (adv) begin
			v_rf <= c1_v[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_rf <= nxt_rf;
		end
	end

	// Second chain: nearest entry to the reflected color.
	assign c2_d[0] = item_rf;
	assign c2_v[0] = v_rf;

	generate
		for (genvar k = 1; k < N; k++) begin : g_chain2
			pod_cell #(.IDX(k)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.adv   (adv),
				.lim   (palette_size_q),
				.vin   (c2_v[k-1]),
				.din   (c2_d[k-1]),
				.vout  (c2_v[k]),
				.dout  (c2_d[k])
			);
		end
	endgenerate

	// Decision, first stage: channel differences and the Bayer threshold. The
	// color terms only count between two colors whose alpha is not zero.
	assign tail2 = c2_d[N-1];

	always_comb begin
		logic [7:0] a1, a2;
		a1 = (tail2.best1 != 5'd0) ? 8'd255 : 8'd0;
		a2 = (tail2.best != 5'd0) ? 8'd255 : 8'd0;
		nxt_da = '0;
		nxt_da.op = tail2.op;
		nxt_da.pa = tail2.pa;
		nxt_da.i1 = tail2.best1;
		nxt_da.i2 = tail2.best;
		nxt_da.col1 = tail2.col1;
		nxt_da.col2 = tail2.bcol;
		nxt_da.c0 = tail2.c0;
		if (a1 != 8'd0 && tail2.pa != 8'd0) begin
			nxt_da.dr = pod_pkg::absdiff8(tail2.col1[23:16], tail2.pr);
			nxt_da.dg = pod_pkg::absdiff8(tail2.col1[15:8], tail2.pg);
			nxt_da.db = pod_pkg::absdiff8(tail2.col1[7:0], tail2.pb);
		end
		nxt_da.da = pod_pkg::absdiff8(a1, tail2.pa);
		if (a1 != 8'd0 && a2 != 8'd0) begin
			nxt_da.er = pod_pkg::absdiff8(tail2.col1[23:16], tail2.bcol[23:16]);
			nxt_da.eg = pod_pkg::absdiff8(tail2.col1[15:8], tail2.bcol[15:8]);
			nxt_da.eb = pod_pkg::absdiff8(tail2.col1[7:0], tail2.bcol[7:0]);
		end
		nxt_da.ea = pod_pkg::absdiff8(a1, a2);
		nxt_da.th1 = 7'(pod_pkg::BAYER[{tail2.yp, tail2.xp}]) + 7'd1;
	end

	// Second stage: weighted distances from the nearest color to the pixel and
	// to the second candidate.
	always_comb begin
		nxt_db = dec_da;
		nxt_db.d = 23'(dec_da.dr * pod_pkg::K_RED) + 23'(dec_da.dg * pod_pkg::K_GREEN)
			+ 23'(dec_da.db * pod_pkg::K_BLUE) + 23'(dec_da.da * pod_pkg::K_ALPHA);
		nxt_db.dd = 23'(dec_da.er * pod_pkg::K_RED) + 23'(dec_da.eg * pod_pkg::K_GREEN)
			+ 23'(dec_da.eb * pod_pkg::K_BLUE) + 23'(dec_da.ea * pod_pkg::K_ALPHA);
	end

	// Third stage: both sides of 64*d >= (th+1)*D.
	always_comb begin
		nxt_dc = dec_db;
		nxt_dc.d64 = {dec_db.d, 6'b000000};
		nxt_dc.m = 29'(dec_db.th1 * dec_db.dd);
	end

	// Last stage: pick the candidate.
	always_comb begin
		idx_nx = dec_dc.i1;
		col_nx = dec_dc.col1;
		if (dec_dc.pa == 8'd0) begin
			idx_nx = '0;
			col_nx = dec_dc.c0;
		end else if (dec_dc.i1 != dec_dc.i2 && dec_dc.dd != 23'd0
				&& dec_dc.d64 >= dec_dc.m) begin
			idx_nx = dec_dc.i2;
			col_nx = dec_dc.col2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_da <= 1'b0;
			v_db <= 1'b0;
			v_dc <= 1'b0;
			v_dd <= 1'b0;
		end else if (adv) begin
			v_da <= c2_v[N-1];
			v_db <= v_da;
			v_dc <= v_db;
			v_dd <= v_dc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_da <= nxt_da;
			dec_db <= nxt_db;
			dec_dc <= nxt_dc;
			op_dd <= dec_dc.op;
			idx_dd <= idx_nx;
			col_dd <= col_nx;
			alpha_dd <= dec_dc.pa;
		end
	end

	// Palette writes leave the pipeline here without a result.
	assign m_tvalid = v_dd && op_dd;
	assign m_tdata = {3'b000, alpha_dd, col_dd[7:0], col_dd[15:8], col_dd[23:16], idx_dd};

endmodule
`default_nettype wire

FILE: hdl/pod_checker.sv
`default_nettype none
module pod_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36:29] == 8'd0 |-> m_tdata[4:0] == 5'd0)
		else $error("transparent pixel not mapped to entry 0");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:37] == 3'b000)
		else $error("result padding not zero");

endmodule

bind palette_ordered_dither pod_checker u_pod_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

FILE: tb/testbench.sv
module testbench;

	// One input transfer as the sender sees it, before packing into tdata/tuser.
	typedef struct {
		logic       opcode;
		logic [4:0] entry_index;
		logic [7:0] entry_red;
		logic [7:0] entry_green;
		logic [7:0] entry_blue;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic [7:0] pixel_alpha;
		logic [2:0] x_phase;
		logic [2:0] y_phase;
	} pod_item_t;

	// One dithered pixel as it leaves the block.
	typedef struct {
		logic [4:0] palette_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} pod_pixel_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;
	localparam int DRAIN_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        palette_size_we = 1'b0;
	logic [5:0]  palette_size_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// entry_index, entry_red, entry_green, entry_blue, pixel_red, pixel_green,
	// pixel_blue, pixel_alpha, x_phase, y_phase; bits 71:67 are zero
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 1'b0; // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// palette_index, out_red, out_green, out_blue, out_alpha; bits 39:37 are zero
	logic [39:0] m_tdata;

	palette_ordered_dither dut (
		.clk(clk),
		.arst_n(arst_n),
		.palette_size_we(palette_size_we),
		.palette_size_wdata(palette_size_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items waiting for the driver, and pixels whose result is still owed.
	pod_item_t  pending_items[$];
	pod_pixel_t owed_pixels[$];
	bit         failed = 1'b0;

	// Our own copy of the block's palette and size register. The copy is updated
	// when a write transfer is accepted, which matches the block: a pixel sees
	// the palette as it stood when the pixel itself was accepted.
	logic [7:0] model_red[32];
	logic [7:0] model_green[32];
	logic [7:0] model_blue[32];
	logic [5:0] model_size = pod_pkg::PALETTE_SIZE_RESET;

	// A separate copy kept by the stimulus generator, so that pixels can be
	// aimed close to colors that will be in the palette when they arrive.
	logic [7:0] gen_red[32];
	logic [7:0] gen_green[32];
	logic [7:0] gen_blue[32];

	function automatic int unsigned sq_term(input int a, input int b, input int unsigned w2);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		return d * d * w2;
	endfunction

	// First index from 1 with the lowest weighted 5-bit distance; 0 if nothing is
	// searched or the pixel is fully transparent.
	function automatic logic [4:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		int unsigned lim;
		int unsigned lowest;
		int unsigned s;
		logic [4:0]  best;
		if (a == 8'd0)
			return 5'd0;
		lim = (model_size > 6'd32) ? 32 : int'(model_size);
		best = 5'd0;
		lowest = 32'hFFFF_FFFF;
		for (int i = 1; i < lim; i++) begin
			s = sq_term(int'(model_green[i] >> 3), int'(g >> 3), 3481)
				+ sq_term(int'(model_red[i] >> 3), int'(r >> 3), 900)
				+ sq_term(int'(model_blue[i] >> 3), int'(b >> 3), 121)
				+ sq_term(31, int'(a >> 3), 64);
			if (s < lowest) begin
				best = 5'(i);
				lowest = s;
				if (s == 0)
					break;
			end
		end
		return best;
	endfunction

	function automatic logic [7:0] mirror(input logic [7:0] p, input logic [7:0] e);
		int v;
		v = 2 * int'(p) - int'(e);
		if (v < 0)
			v = -v;
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	function automatic longint unsigned color_gap(input logic [7:0] ar, input logic [7:0] ag,
			input logic [7:0] ab, input logic [7:0] aa, input logic [7:0] br,
			input logic [7:0] bg, input logic [7:0] bb, input logic [7:0] ba);
		longint unsigned s;
		s = 0;
		if (aa != 0 && ba != 0) begin
			s += longint'(ar > br ? ar - br : br - ar) * 2126;
			s += longint'(ag > bg ? ag - bg : bg - ag) * 7152;
			s += longint'(ab > bb ? ab - bb : bb - ab) * 722;
		end
		s += longint'(aa > ba ? aa - ba : ba - aa) * 20000;
		return s;
	endfunction

	// Works out the result the block owes for one accepted pixel.
	function automatic pod_pixel_t dither_pixel(input pod_item_t it);
		pod_pixel_t       res;
		logic [4:0]       first;
		logic [4:0]       second;
		logic [4:0]       pick;
		logic [7:0]       first_alpha;
		logic [7:0]       second_alpha;
		longint unsigned  d_pix;
		longint unsigned  d_pair;
		longint unsigned  th;
		pick = 5'd0;
		if (it.pixel_alpha != 8'd0) begin
			first = nearest_entry(it.pixel_red, it.pixel_green, it.pixel_blue, it.pixel_alpha);
			first_alpha = (first == 0) ? 8'd0 : 8'd255;
			second = nearest_entry(mirror(it.pixel_red, model_red[first]),
				mirror(it.pixel_green, model_green[first]),
				mirror(it.pixel_blue, model_blue[first]),
				mirror(it.pixel_alpha, first_alpha));
			pick = first;
			if (first != second) begin
				second_alpha = (second == 0) ? 8'd0 : 8'd255;
				d_pix = color_gap(model_red[first], model_green[first], model_blue[first],
					first_alpha, it.pixel_red, it.pixel_green, it.pixel_blue,
					it.pixel_alpha);
				d_pair = color_gap(model_red[first], model_green[first], model_blue[first],
					first_alpha, model_red[second], model_green[second],
					model_blue[second], second_alpha);
				th = longint'(pod_pkg::BAYER[{it.y_phase, it.x_phase}]);
				if (d_pair != 0 && 64 * d_pix >= (th + 1) * d_pair)
					pick = second;
			end
		end
		res.palette_index = pick;
		res.out_red = model_red[pick];
		res.out_green = model_green[pick];
		res.out_blue = model_blue[pick];
		res.out_alpha = it.pixel_alpha;
		return res;
	endfunction

	// Driver: bursts of random length separated by random gaps. The current
	// transfer is held until taken; without a gap, the next is loaded on that edge.
	pod_item_t held;
	int        burst_left = 0;
	int        gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : driver
		bit free;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			free = !s_tvalid;
			if (s_tvalid && s_tready) begin
				if (held.opcode == OP_WRITE) begin
					model_red[held.entry_index] = held.entry_red;
					model_green[held.entry_index] = held.entry_green;
					model_blue[held.entry_index] = held.entry_blue;
				end else begin
					owed_pixels.push_back(dither_pixel(held));
				end
				free = 1'b1;
			end
			if (free) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					held = pending_items.pop_front();
					s_tuser <= held.opcode;
					s_tdata <= {5'd0, held.y_phase, held.x_phase, held.pixel_alpha,
						held.pixel_blue, held.pixel_green, held.pixel_red,
						held.entry_blue, held.entry_green, held.entry_red,
						held.entry_index};
					s_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(40);
						// Some bursts run back to back with no gap at all.
						gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a ready pattern that changes its mode from time to time, plus one
	// long hold-off that starts while plenty of items are still waiting, so the
	// pipeline fills and must back-pressure the input.
	int ready_mode = 0;
	int mode_left = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycle_count++;
			if (mode_left == 0) begin
				ready_mode = $urandom_range(2);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			if (!hold_done && s_tvalid && pending_items.size() > 60) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (ready_mode == 0)
				m_tready <= 1'b1;
			else if (ready_mode == 1)
				m_tready <= ($urandom_range(1) == 1);
			else
				m_tready <= (cycle_count % 4 != 0);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// Monitor: every result transfer is matched against the oldest owed pixel.
	always @(posedge clk) begin : monitor
		pod_pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_pixels.size() == 0) begin
				$error("result transfer with no pixel outstanding: %h", m_tdata);
				failed = 1'b1;
			end else begin
				want = owed_pixels.pop_front();
				check_field("palette_index", want.palette_index, m_tdata[4:0]);
				check_field("out_red", want.out_red, m_tdata[12:5]);
				check_field("out_green", want.out_green, m_tdata[20:13]);
				check_field("out_blue", want.out_blue, m_tdata[28:21]);
				check_field("out_alpha", want.out_alpha, m_tdata[36:29]);
			end
		end
	end

	function automatic pod_item_t palette_write(input logic [4:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		pod_item_t it;
		it = '{default: '0};
		it.opcode = OP_WRITE;
		it.entry_index = idx;
		it.entry_red = r;
		it.entry_green = g;
		it.entry_blue = b;
		// Pixel fields are don't-care on a write, so put noise there.
		it.pixel_red = 8'($urandom);
		it.pixel_alpha = 8'($urandom);
		it.x_phase = 3'($urandom);
		gen_red[idx] = r;
		gen_green[idx] = g;
		gen_blue[idx] = b;
		return it;
	endfunction

	function automatic pod_item_t pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, input logic [2:0] x,
			input logic [2:0] y);
		pod_item_t it;
		it = '{default: '0};
		it.opcode = OP_PIXEL;
		it.pixel_red = r;
		it.pixel_green = g;
		it.pixel_blue = b;
		it.pixel_alpha = a;
		it.x_phase = x;
		it.y_phase = y;
		it.entry_index = 5'($urandom);
		it.entry_red = 8'($urandom);
		return it;
	endfunction

	function automatic logic [7:0] jitter(input logic [7:0] v, input int span);
		int s;
		s = int'(v) + $urandom_range(2 * span) - span;
		return (s < 0) ? 8'd0 : (s > 255) ? 8'd255 : 8'(s);
	endfunction

	function automatic logic [7:0] random_alpha();
		case ($urandom_range(5))
			0: return 8'd0;
			1, 2: return 8'd255;
			3: return 8'($urandom_range(240, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || owed_pixels.size() != 0 || s_tvalid)
			@(posedge clk);
		// Palette writes can still be in flight with nothing owed.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_palette_size(input logic [5:0] value);
		@(posedge clk);
		palette_size_we <= 1'b1;
		palette_size_wdata <= value;
		@(posedge clk);
		palette_size_we <= 1'b0;
		model_size = value;
	endtask

	// Sizes cover the reset value, the low end where nothing is searched, and
	// values past the number of search cells, which must saturate.
	logic [5:0] phase_sizes[8] = '{6'd32, 6'd5, 6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd17};

	initial begin : stimulus
		logic [4:0] k;
		logic [4:0] lim;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Every entry is written before any pixel can read it.
		for (int i = 0; i < 32; i++)
			pending_items.push_back(palette_write(5'(i), 8'($urandom), 8'($urandom),
				8'($urandom)));
		pending_items.push_back(palette_write(5'd1, 8'd0, 8'd0, 8'd0));
		pending_items.push_back(palette_write(5'd2, 8'd255, 8'd255, 8'd255));
		pending_items.push_back(palette_write(5'd31, 8'd255, 8'd0, 8'd255));

		foreach (phase_sizes[p]) begin
			wait_idle();
			set_palette_size(phase_sizes[p]);
			if (p == 0) begin
				pending_items.push_back(pixel(8'd0, 8'd0, 8'd0, 8'd255, 3'd0, 3'd0));
				pending_items.push_back(pixel(8'd255, 8'd255, 8'd255, 8'd255, 3'd7, 3'd7));
				pending_items.push_back(pixel(8'd255, 8'd255, 8'd255, 8'd0, 3'd7, 3'd0));
				pending_items.push_back(pixel(8'd12, 8'd200, 8'd99, 8'd0, 3'd0, 3'd7));
				pending_items.push_back(pixel(8'd128, 8'd128, 8'd128, 8'd1, 3'd3, 3'd4));
				pending_items.push_back(pixel(8'd128, 8'd128, 8'd128, 8'd254, 3'd4, 3'd3));
				pending_items.push_back(pixel(8'd255, 8'd0, 8'd255, 8'd255, 3'd1, 3'd2));
				pending_items.push_back(pixel(8'd127, 8'd127, 8'd127, 8'd255, 3'd0, 3'd7));
				pending_items.push_back(pixel(8'd127, 8'd127, 8'd127, 8'd255, 3'd7, 3'd0));
				// Two entries of the same color: the lower index must win.
				pending_items.push_back(palette_write(5'd3, 8'd64, 8'd64, 8'd64));
				pending_items.push_back(palette_write(5'd4, 8'd64, 8'd64, 8'd64));
				pending_items.push_back(pixel(8'd64, 8'd64, 8'd64, 8'd255, 3'd2, 3'd5));
				pending_items.push_back(pixel(8'd70, 8'd60, 8'd66, 8'd200, 3'd6, 3'd1));
				// A write right behind a pixel must not affect that pixel.
				pending_items.push_back(pixel(8'd250, 8'd250, 8'd250, 8'd255, 3'd5, 3'd6));
				pending_items.push_back(palette_write(5'd2, 8'd0, 8'd0, 8'd0));
				pending_items.push_back(pixel(8'd250, 8'd250, 8'd250, 8'd255, 3'd5, 3'd6));
			end
			for (int n = 0; n < 88; n++) begin
				if ($urandom_range(7) == 0) begin
					pending_items.push_back(palette_write(5'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom)));
				end else if ($urandom_range(1) == 0) begin
					// Aim near an entry in use so both candidates are close.
					lim = (phase_sizes[p] > 6'd31 || phase_sizes[p] < 6'd2) ?
						5'd31 : 5'(phase_sizes[p] - 1);
					k = 5'($urandom_range(lim));
					pending_items.push_back(pixel(jitter(gen_red[k], 24),
						jitter(gen_green[k], 24), jitter(gen_blue[k], 24),
						random_alpha(), 3'($urandom), 3'($urandom)));
				end else begin
					pending_items.push_back(pixel(8'($urandom), 8'($urandom), 8'($urandom),
						random_alpha(), 3'($urandom), 3'($urandom)));
				end
			end
		end

		wait_idle();
		if (!failed)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: palette_ordered_dither.f
hdl/pod_pkg.sv
hdl/pod_cell.sv
hdl/palette_ordered_dither.sv
hdl/pod_checker.sv
tb/testbench.sv
